[design/deu_pkg.sv]
// Shared types, codes and detector mapping tables for the event word unpacker.
package deu_pkg;

   localparam int unsigned NUM_ADCS = 5;
   localparam int unsigned ADC_W    = 3;
   localparam int unsigned CHAN_W   = 4;
   localparam int unsigned DET_W    = 5;
   localparam int unsigned SIG_W    = 2;
   localparam int unsigned VALUE_W  = 12;
   localparam int unsigned HITS_W   = 5;
   localparam int unsigned KIND_W   = 3;

   localparam logic [ADC_W-1:0] LAST_ADC = ADC_W'(NUM_ADCS - 1);

   // result word classes
   localparam logic [KIND_W-1:0] KIND_AUX      = 3'd0;
   localparam logic [KIND_W-1:0] KIND_TIMING   = 3'd1;
   localparam logic [KIND_W-1:0] KIND_HIT_REG  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_MAPPED   = 3'd3;
   localparam logic [KIND_W-1:0] KIND_UNMAPPED = 3'd4;
   localparam logic [KIND_W-1:0] KIND_IGNORED  = 3'd5;

   typedef logic [DET_W-1:0] det_row_type [0:15];
   typedef logic [SIG_W-1:0] sig_row_type [0:15];

   localparam det_row_type DET_MAP [0:NUM_ADCS-1] = '{
      '{5'd1,  5'd0,  5'd5,  5'd4,  5'd3,  5'd2,  5'd1,  5'd0,
        5'd3,  5'd2,  5'd1,  5'd0,  5'd5,  5'd4,  5'd3,  5'd2},
      '{5'd11, 5'd10, 5'd9,  5'd8,  5'd7,  5'd6,  5'd5,  5'd4,
        5'd7,  5'd6,  5'd11, 5'd10, 5'd9,  5'd8,  5'd7,  5'd6},
      '{5'd15, 5'd14, 5'd13, 5'd12, 5'd11, 5'd10, 5'd9,  5'd8,
        5'd17, 5'd16, 5'd15, 5'd14, 5'd13, 5'd12, 5'd17, 5'd16},
      '{5'd20, 5'd21, 5'd22, 5'd23, 5'd18, 5'd19, 5'd20, 5'd21,
        5'd12, 5'd13, 5'd14, 5'd15, 5'd16, 5'd17, 5'd18, 5'd19},
      '{5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,
        5'd22, 5'd23, 5'd18, 5'd19, 5'd20, 5'd21, 5'd22, 5'd23}
   };

   localparam sig_row_type SIG_MAP [0:NUM_ADCS-1] = '{
      '{2'd1, 2'd1, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0,
        2'd2, 2'd2, 2'd2, 2'd2, 2'd1, 2'd1, 2'd1, 2'd1},
      '{2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd2, 2'd2,
        2'd2, 2'd2, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1},
      '{2'd0, 2'd0, 2'd0, 2'd0, 2'd2, 2'd2, 2'd2, 2'd2,
        2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd0, 2'd0},
      '{2'd0, 2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd1, 2'd1,
        2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd0, 2'd0},
      '{2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0,
        2'd1, 2'd1, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2}
   };

   // bit c set: channel c of that converter has a detector
   localparam logic [15:0] MAP_VALID [0:NUM_ADCS-1] = '{
      16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFF00
   };

   // classified word as it travels from front to back
   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [ADC_W-1:0]   adc;
      logic [CHAN_W-1:0]  chan;
      logic [VALUE_W-1:0] value;
      logic [HITS_W-1:0]  hits;
      logic               done;
   } deu_entry_type;

   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_W      = 2;

endpackage

[design/detector_event_word_unpacker.sv]
// Top level of the detector event word unpacker.
//
//   channel | direction | handshake           | content
//   req_    | in        | req_valid/req_ready | raw event word, first-word flag
//   rsp_    | out       | rsp_valid/rsp_ready | classified word, one per input word
//
// One word a cycle sustained while rsp_ready stays high; a taken word reaches
// rsp_ by way of the queue entry, written on the taking edge, and then the
// result register.
// The parse state moves on each accepted word in the front end; a 4-entry
// queue lets the front keep taking words while the result register stalls.
// req_ready falls only when the queue is full. Synchronous reset empties the
// queue and drops the parse to waiting for a first word.
module detector_event_word_unpacker #(
   parameter int unsigned AUX_WORDS = 16,
   parameter int unsigned TDC_WORDS = 6
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [31:0]                 req_data_word,
   input  logic                        req_first_word,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [deu_pkg::KIND_W-1:0]  rsp_kind,
   output logic [deu_pkg::ADC_W-1:0]   rsp_adc_number,
   output logic [deu_pkg::CHAN_W-1:0]  rsp_channel,
   output logic [deu_pkg::DET_W-1:0]   rsp_detector,
   output logic [deu_pkg::SIG_W-1:0]   rsp_signal,
   output logic [deu_pkg::VALUE_W-1:0] rsp_value,
   output logic [deu_pkg::HITS_W-1:0]  rsp_hit_count,
   output logic                        rsp_event_done
);
   import deu_pkg::*;

   logic          push, not_full, pop, not_empty;
   deu_entry_type front_entry, q_entry;

   // a word is taken whenever the queue has room
   assign req_ready = not_full;
   assign push      = req_valid && not_full;

   deu_front #(
      .AUX_WORDS (AUX_WORDS),
      .TDC_WORDS (TDC_WORDS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .data_word  (req_data_word),
      .first_word (req_first_word),
      .push       (push),
      .entry      (front_entry)
   );

   deu_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (front_entry),
      .not_full   (not_full),
      .pop        (pop),
      .pop_entry  (q_entry),
      .not_empty  (not_empty)
   );

   // table lookup happens on the way into the result register
   deu_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_not_empty    (not_empty),
      .q_entry        (q_entry),
      .q_pop          (pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_kind       (rsp_kind),
      .rsp_adc_number (rsp_adc_number),
      .rsp_channel    (rsp_channel),
      .rsp_detector   (rsp_detector),
      .rsp_signal     (rsp_signal),
      .rsp_value      (rsp_value),
      .rsp_hit_count  (rsp_hit_count),
      .rsp_event_done (rsp_event_done)
   );

endmodule

[design/deu_front.sv]
// Front end: accepts words, tracks the event parse and classifies each word.
module deu_front #(
   parameter int unsigned AUX_WORDS = 16,
   parameter int unsigned TDC_WORDS = 6
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [31:0]            data_word,
   input  logic                   first_word,
   input  logic                   push,
   output deu_pkg::deu_entry_type entry
);
   import deu_pkg::*;

   localparam logic [2:0] PH_AUX  = 3'd0;
   localparam logic [2:0] PH_TDC  = 3'd1;
   localparam logic [2:0] PH_HIT  = 3'd2;
   localparam logic [2:0] PH_ARR  = 3'd3;
   localparam logic [2:0] PH_DONE = 3'd4;

   localparam logic [3:0] AUX_LAST = 4'(AUX_WORDS - 1);
   localparam logic [3:0] TDC_LAST = 4'(TDC_WORDS - 1);

   logic [2:0]        phase_ff, phase_in, ph;
   logic [3:0]        word_ff, word_in, wi;
   logic [ADC_W-1:0]  adc_ff, adc_in, ai, ac;
   logic [HITS_W-1:0] hits_ff, hits_in, hl, hl_dec, pop;
   logic [CHAN_W-1:0] ch;

   always_comb begin
      // a first word restarts the parse
      ph = first_word ? PH_AUX : phase_ff;
      wi = first_word ? 4'd0 : word_ff;
      ai = first_word ? '0 : adc_ff;
      hl = first_word ? '0 : hits_ff;

      phase_in = ph;
      word_in  = wi;
      adc_in   = ai;
      hits_in  = hl;

      pop    = HITS_W'($countones(data_word[15:0]));
      ac     = (ai > LAST_ADC) ? LAST_ADC : ai;
      ch     = data_word[15:12];
      hl_dec = (hl != '0) ? hl - 1'b1 : hl;

      entry.kind  = KIND_IGNORED;
      entry.adc   = '0;
      entry.chan  = '0;
      entry.value = data_word[VALUE_W-1:0];
      entry.hits  = '0;
      entry.done  = 1'b0;

      case (ph)
         PH_AUX: begin
            entry.kind = KIND_AUX;
            entry.chan = wi;
            if (wi >= AUX_LAST) begin
               phase_in = PH_TDC;
               word_in  = 4'd0;
            end else begin
               word_in = wi + 4'd1;
            end
         end
         PH_TDC: begin
            entry.kind = KIND_TIMING;
            entry.chan = wi;
            if (wi >= TDC_LAST) begin
               phase_in = PH_HIT;
               word_in  = 4'd0;
               adc_in   = '0;
            end else begin
               word_in = wi + 4'd1;
            end
         end
         PH_HIT: begin
            entry.kind = KIND_HIT_REG;
            entry.adc  = ai;
            entry.hits = pop;
            if (pop != '0) begin
               hits_in  = pop;
               phase_in = PH_ARR;
            end else if (ai >= LAST_ADC) begin
               phase_in   = PH_DONE;
               adc_in     = '0;
               entry.done = 1'b1;
            end else begin
               adc_in   = ai + 1'b1;
               phase_in = PH_HIT;
            end
         end
         PH_ARR: begin
            entry.adc  = ac;
            entry.chan = ch;
            entry.kind = MAP_VALID[ac][ch] ? KIND_MAPPED : KIND_UNMAPPED;
            hits_in    = hl_dec;
            if (hl_dec == '0) begin
               if (ai >= LAST_ADC) begin
                  phase_in   = PH_DONE;
                  adc_in     = '0;
                  entry.done = 1'b1;
               end else begin
                  adc_in   = ai + 1'b1;
                  phase_in = PH_HIT;
               end
            end
         end
         default: begin
            entry.kind = KIND_IGNORED;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_DONE;
         word_ff  <= '0;
         adc_ff   <= '0;
         hits_ff  <= '0;
      end else if (push) begin
         phase_ff <= phase_in;
         word_ff  <= word_in;
         adc_ff   <= adc_in;
         hits_ff  <= hits_in;
      end
   end

endmodule

[design/deu_queue.sv]
// Short queue of classified words between front and back.
module deu_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  deu_pkg::deu_entry_type push_entry,
   output logic                   not_full,
   input  logic                   pop,
   output deu_pkg::deu_entry_type pop_entry,
   output logic                   not_empty
);
   import deu_pkg::*;

   deu_entry_type       mem_ff [0:QUEUE_DEPTH-1];
   logic [QPTR_W-1:0]   wr_ff, rd_ff;
   logic [QPTR_W:0]     count_ff;

   assign not_full  = (count_ff != (QPTR_W+1)'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_entry = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= wr_ff + 1'b1;
         end
         if (pop) begin
            rd_ff <= rd_ff + 1'b1;
         end
         case ({push, pop})
            2'b10:   count_ff <= count_ff + 1'b1;
            2'b01:   count_ff <= count_ff - 1'b1;
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

[design/deu_back.sv]
// Back end: detector and signal lookup into the result register.
module deu_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        q_not_empty,
   input  deu_pkg::deu_entry_type      q_entry,
   output logic                        q_pop,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [deu_pkg::KIND_W-1:0]  rsp_kind,
   output logic [deu_pkg::ADC_W-1:0]   rsp_adc_number,
   output logic [deu_pkg::CHAN_W-1:0]  rsp_channel,
   output logic [deu_pkg::DET_W-1:0]   rsp_detector,
   output logic [deu_pkg::SIG_W-1:0]   rsp_signal,
   output logic [deu_pkg::VALUE_W-1:0] rsp_value,
   output logic [deu_pkg::HITS_W-1:0]  rsp_hit_count,
   output logic                        rsp_event_done
);
   import deu_pkg::*;

   logic               valid_ff;
   deu_entry_type      entry_ff;
   logic [DET_W-1:0]   det_ff, det_in;
   logic [SIG_W-1:0]   sig_ff, sig_in;
   logic [ADC_W-1:0]   a;

   assign q_pop = q_not_empty && (!valid_ff || rsp_ready);

   always_comb begin
      a      = (q_entry.adc > LAST_ADC) ? LAST_ADC : q_entry.adc;
      det_in = '0;
      sig_in = '0;
      if (q_entry.kind == KIND_MAPPED) begin
         det_in = DET_MAP[a][q_entry.chan];
         sig_in = SIG_MAP[a][q_entry.chan];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (q_pop) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         entry_ff <= q_entry;
         det_ff   <= det_in;
         sig_ff   <= sig_in;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_kind       = entry_ff.kind;
   assign rsp_adc_number = entry_ff.adc;
   assign rsp_channel    = entry_ff.chan;
   assign rsp_detector   = det_ff;
   assign rsp_signal     = sig_ff;
   assign rsp_value      = entry_ff.value;
   assign rsp_hit_count  = entry_ff.hits;
   assign rsp_event_done = entry_ff.done;

endmodule

[verif/tb_detector_event_word_unpacker.sv]
// Self-checking testbench for the detector event word unpacker: directed table, then random events.
`timescale 1ns / 100ps

module tb_detector_event_word_unpacker;
   import deu_pkg::*;

   localparam int unsigned AUX_COUNT    = 16;
   localparam int unsigned TDC_COUNT    = 6;
   localparam int unsigned RANDOM_WORDS = 550;
   // last stretch of the run goes at full rate on both sides
   localparam int unsigned CALM_FROM    = RANDOM_WORDS * 4 / 5;

   localparam logic [SIG_W-1:0] SIG_ENERGY = 2'd0;
   localparam logic [SIG_W-1:0] SIG_FAR    = 2'd1;
   localparam logic [SIG_W-1:0] SIG_NEAR   = 2'd2;

   // converter/channel to detector and signal, own copy of the cabling
   localparam logic [DET_W-1:0] DETECTOR_OF [0:4][0:15] = '{
      '{ 1,  0,  5,  4,  3,  2,  1,  0,  3,  2,  1,  0,  5,  4,  3,  2},
      '{11, 10,  9,  8,  7,  6,  5,  4,  7,  6, 11, 10,  9,  8,  7,  6},
      '{15, 14, 13, 12, 11, 10,  9,  8, 17, 16, 15, 14, 13, 12, 17, 16},
      '{20, 21, 22, 23, 18, 19, 20, 21, 12, 13, 14, 15, 16, 17, 18, 19},
      '{ 0,  0,  0,  0,  0,  0,  0,  0, 22, 23, 18, 19, 20, 21, 22, 23}
   };
   localparam logic [SIG_W-1:0] SIGNAL_OF [0:4][0:15] = '{
      '{1, 1, 0, 0, 0, 0, 0, 0, 2, 2, 2, 2, 1, 1, 1, 1},
      '{0, 0, 0, 0, 0, 0, 2, 2, 2, 2, 1, 1, 1, 1, 1, 1},
      '{0, 0, 0, 0, 2, 2, 2, 2, 1, 1, 1, 1, 1, 1, 0, 0},
      '{0, 0, 0, 0, 1, 1, 1, 1, 2, 2, 2, 2, 2, 2, 0, 0},
      '{0, 0, 0, 0, 0, 0, 0, 0, 1, 1, 2, 2, 2, 2, 2, 2}
   };
   // converter 4 has nothing cabled on channels 0..7
   localparam logic [15:0] CHANNEL_CABLED [0:4] = '{
      16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFF00
   };

   typedef enum logic [2:0] {
      PARSE_AUX, PARSE_TIMING, PARSE_HIT_REG, PARSE_ARRAY, PARSE_IDLE
   } parse_phase_type;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [ADC_W-1:0]   adc;
      logic [CHAN_W-1:0]  chan;
      logic [DET_W-1:0]   det;
      logic [SIG_W-1:0]   sig;
      logic [VALUE_W-1:0] value;
      logic [HITS_W-1:0]  hits;
      logic               done;
   } word_class_type;

   // one row of the directed table: word, flag, repeat count, and a typed
   // classification where it is obvious (otherwise the predictor decides)
   typedef struct packed {
      logic [31:0]    data;
      logic           first;
      logic [4:0]     reps;
      logic           typed;
      word_class_type want;
   } table_row_type;

   localparam word_class_type PREDICTED = '0;

   localparam int unsigned TABLE_ROWS = 17;
   localparam table_row_type DIRECTED [0:TABLE_ROWS-1] = '{
      // stray words straight after reset are ignored
      {32'hFFFF_FFFF, 1'b0, 5'd1, 1'b1,
       KIND_IGNORED, 3'd0, 4'd0, 5'd0, SIG_ENERGY, 12'hFFF, 5'd0, 1'b0},
      {32'h0000_0000, 1'b0, 5'd1, 1'b1,
       KIND_IGNORED, 3'd0, 4'd0, 5'd0, SIG_ENERGY, 12'h000, 5'd0, 1'b0},
      {32'hFFFF_FFFF, 1'b1, 5'd1, 1'b1,
       KIND_AUX, 3'd0, 4'd0, 5'd0, SIG_ENERGY, 12'hFFF, 5'd0, 1'b0},
      {32'h1234_5678, 1'b0, 5'd3, 1'b0, PREDICTED},
      // restart part way through the aux block
      {32'hABCD_E123, 1'b1, 5'd1, 1'b1,
       KIND_AUX, 3'd0, 4'd0, 5'd0, SIG_ENERGY, 12'h123, 5'd0, 1'b0},
      {32'h5A5A_A5A5, 1'b0, 5'd15, 1'b0, PREDICTED},
      {32'h8000_0FFF, 1'b0, 5'd6, 1'b0, PREDICTED},
      // converter 0 empty: hit bits only in the upper half
      {32'hFFFF_0000, 1'b0, 5'd1, 1'b1,
       KIND_HIT_REG, 3'd0, 4'd0, 5'd0, SIG_ENERGY, 12'h000, 5'd0, 1'b0},
      {32'h0000_0001, 1'b0, 5'd1, 1'b0, PREDICTED},
      {32'h0000_F000, 1'b0, 5'd1, 1'b1,
       KIND_MAPPED, 3'd1, 4'd15, 5'd6, SIG_FAR, 12'h000, 5'd0, 1'b0},
      {32'h0000_0000, 1'b0, 5'd1, 1'b0, PREDICTED},
      {32'h0000_8000, 1'b0, 5'd1, 1'b0, PREDICTED},
      {32'h0000_0ABC, 1'b0, 5'd1, 1'b0, PREDICTED},
      {32'h0000_0101, 1'b0, 5'd1, 1'b0, PREDICTED},
      // converter 4 channel 0 has no detector
      {32'hFFFF_0FFF, 1'b0, 5'd1, 1'b1,
       KIND_UNMAPPED, 3'd4, 4'd0, 5'd0, SIG_ENERGY, 12'hFFF, 5'd0, 1'b0},
      {32'h0000_8000, 1'b0, 5'd1, 1'b1,
       KIND_MAPPED, 3'd4, 4'd8, 5'd22, SIG_FAR, 12'h000, 5'd0, 1'b1},
      {32'h7FFF_F000, 1'b0, 5'd1, 1'b1,
       KIND_IGNORED, 3'd0, 4'd0, 5'd0, SIG_ENERGY, 12'h000, 5'd0, 1'b0}
   };

   logic                 clock          = 1'b0;
   logic                 reset          = 1'b1;
   logic                 req_valid      = 1'b0;
   logic                 req_ready;
   logic [31:0]          req_data_word  = '0;
   logic                 req_first_word = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_ready      = 1'b0;
   logic [KIND_W-1:0]    rsp_kind;
   logic [ADC_W-1:0]     rsp_adc_number;
   logic [CHAN_W-1:0]    rsp_channel;
   logic [DET_W-1:0]     rsp_detector;
   logic [SIG_W-1:0]     rsp_signal;
   logic [VALUE_W-1:0]   rsp_value;
   logic [HITS_W-1:0]    rsp_hit_count;
   logic                 rsp_event_done;

   // classification typed in the table travels alongside the word on the bus
   logic                 row_typed = 1'b0;
   word_class_type       row_want  = '0;

   // predictor state, starts as after reset
   parse_phase_type      parse_phase = PARSE_IDLE;
   logic [3:0]           word_pos    = '0;
   logic [ADC_W-1:0]     adc_pos     = '0;
   logic [HITS_W-1:0]    hits_due    = '0;

   word_class_type       expected_words [$];
   int unsigned          failures    = 0;
   int unsigned          words_sent  = 0;
   int unsigned          event_pos   = 0;
   int unsigned          event_cut   = 0;
   int unsigned          stall_left  = 0;
   logic                 calm        = 1'b0;

   detector_event_word_unpacker #(
      .AUX_WORDS(AUX_COUNT),
      .TDC_WORDS(TDC_COUNT)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data_word(req_data_word),
      .req_first_word(req_first_word),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_kind(rsp_kind),
      .rsp_adc_number(rsp_adc_number),
      .rsp_channel(rsp_channel),
      .rsp_detector(rsp_detector),
      .rsp_signal(rsp_signal),
      .rsp_value(rsp_value),
      .rsp_hit_count(rsp_hit_count),
      .rsp_event_done(rsp_event_done)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // step to the next converter's hit register; 1 when the event is over
   function automatic logic close_adc();
      if (adc_pos >= LAST_ADC) begin
         parse_phase = PARSE_IDLE;
         adc_pos     = '0;
         return 1'b1;
      end
      adc_pos     = adc_pos + 1'b1;
      parse_phase = PARSE_HIT_REG;
      return 1'b0;
   endfunction

   // classify one accepted word and move the parse on
   function automatic word_class_type classify_word(input logic [31:0] w, input logic first);
      word_class_type   r;
      logic [ADC_W-1:0] a;
      logic [3:0]       c;
      r       = '0;
      r.kind  = KIND_IGNORED;
      r.value = w[11:0];
      if (first) begin
         parse_phase = PARSE_AUX;
         word_pos    = '0;
         adc_pos     = '0;
         hits_due    = '0;
      end
      case (parse_phase)
         PARSE_AUX: begin
            r.kind = KIND_AUX;
            r.chan = word_pos;
            if (word_pos >= AUX_COUNT - 1) begin
               parse_phase = PARSE_TIMING;
               word_pos    = '0;
            end else
               word_pos = word_pos + 1'b1;
         end
         PARSE_TIMING: begin
            r.kind = KIND_TIMING;
            r.chan = word_pos;
            if (word_pos >= TDC_COUNT - 1) begin
               parse_phase = PARSE_HIT_REG;
               word_pos    = '0;
               adc_pos     = '0;
            end else
               word_pos = word_pos + 1'b1;
         end
         PARSE_HIT_REG: begin
            r.kind = KIND_HIT_REG;
            r.adc  = adc_pos;
            r.hits = HITS_W'($countones(w[15:0]));
            if (r.hits != 0) begin
               hits_due    = r.hits;
               parse_phase = PARSE_ARRAY;
            end else
               r.done = close_adc();
         end
         PARSE_ARRAY: begin
            a      = (adc_pos < NUM_ADCS) ? adc_pos : LAST_ADC;
            c      = w[15:12];
            r.adc  = a;
            r.chan = c;
            if (CHANNEL_CABLED[a][c]) begin
               r.kind = KIND_MAPPED;
               r.det  = DETECTOR_OF[a][c];
               r.sig  = SIGNAL_OF[a][c];
            end else
               r.kind = KIND_UNMAPPED;
            if (hits_due != 0)
               hits_due = hits_due - 1'b1;
            if (hits_due == 0)
               r.done = close_adc();
         end
         default: r.kind = KIND_IGNORED;
      endcase
      return r;
   endfunction

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         failures++;
      end
   endfunction

   // offer one word, with an occasional idle burst first, and wait for it to go
   task automatic send_word(input logic [31:0] data, input logic first, input logic typed,
                            input word_class_type want);
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_data_word  <= data;
      req_first_word <= first;
      row_typed      <= typed;
      row_want       <= want;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
   endtask

   // word of a random event; dropped once the event has been cut short
   task automatic event_word(input logic [31:0] data, input logic first);
      if (event_cut == 0 || event_pos < event_cut) begin
         send_word(data, first, 1'b0, '0);
         event_pos++;
         words_sent++;
         if (words_sent >= CALM_FROM)
            calm <= 1'b1;
      end
   endtask

   // well-formed event with random content; hit counts lean to small,
   // with empty converters and the full sixteen now and then
   task automatic random_event();
      int unsigned r;
      int unsigned hc;
      logic [15:0] mask;
      event_word($urandom, 1'b1);
      repeat (AUX_COUNT + TDC_COUNT - 1) event_word($urandom, 1'b0);
      for (int a = 0; a < NUM_ADCS; a++) begin
         r    = $urandom_range(0, 19);
         hc   = (r < 5) ? 0 : (r == 5) ? 16 : $urandom_range(1, 4);
         mask = '0;
         while ($countones(mask) < hc)
            mask[$urandom_range(0, 15)] = 1'b1;
         event_word({16'($urandom), mask}, 1'b0);
         repeat (hc) event_word($urandom, 1'b0);
      end
   endtask

   // result side: random stall bursts, none in the calm stretch
   always @(posedge clock) begin
      if (stall_left != 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= $urandom_range(0, 3);
      end else
         rsp_ready <= 1'b1;
   end

   // record the expectation for each accepted word, then check each result
   // word against the oldest one; pushing first keeps this order-safe
   always @(posedge clock) begin
      word_class_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            want = classify_word(req_data_word, req_first_word);
            if (row_typed)
               want = row_want;
            expected_words.push_back(want);
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_words.size() == 0) begin
               $error("result word with no word outstanding");
               failures++;
            end else begin
               want = expected_words.pop_front();
               check_field("kind", want.kind, rsp_kind);
               check_field("adc_number", want.adc, rsp_adc_number);
               check_field("channel", want.chan, rsp_channel);
               check_field("detector", want.det, rsp_detector);
               check_field("signal", want.sig, rsp_signal);
               check_field("value", want.value, rsp_value);
               check_field("hit_count", want.hits, rsp_hit_count);
               check_field("event_done", want.done, rsp_event_done);
            end
         end
      end
   end

   initial begin
      int unsigned pick;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED[i])
         repeat (DIRECTED[i].reps)
            send_word(DIRECTED[i].data, DIRECTED[i].first, DIRECTED[i].typed,
                      DIRECTED[i].want);

      // random events, a few cut short by a restart, with stray words between
      while (words_sent < RANDOM_WORDS) begin
         pick = $urandom_range(0, 19);
         if (pick == 0)
            repeat ($urandom_range(1, 3)) send_word($urandom, 1'b0, 1'b0, '0);
         else begin
            event_pos = 0;
            event_cut = (pick <= 2) ? $urandom_range(1, 45) : 0;
            random_event();
         end
      end
      req_valid <= 1'b0;

      while (expected_words.size() != 0)
         @(posedge clock);
      // pipe plus queue: the extra wait catches any stray extra result word
      repeat (10) @(posedge clock);

      if (failures == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   // hang guard, far beyond the slowest legal run
   initial begin
      #(2_000_000);
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

[sim.f]
design/deu_pkg.sv
design/deu_front.sv
design/deu_queue.sv
design/deu_back.sv
design/detector_event_word_unpacker.sv
verif/tb_detector_event_word_unpacker.sv
